[rtl/quad_view_video_compositor_core_defines.svh]
// Assertion macros shared by the quad-view compositor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef QUAD_VIEW_VIDEO_COMPOSITOR_CORE_DEFINES_SVH
`define QUAD_VIEW_VIDEO_COMPOSITOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define QVVC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qvvc assertion failed");
`define QVVC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("qvvc forbidden condition seen");
`else
`define QVVC_ASSERT(lbl, clk, rst_n, prop)
`define QVVC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/qvvc_pkg.sv]
// Types and fixed constants of the quad-view video compositor.
// Depends on nothing; imported by the front end, the back end and the top level.
`timescale 1ns / 1ps

package qvvc_pkg;

    localparam int CH_W      = 8;
    localparam int SIZE_W    = 11;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 10;
    localparam int PROD_W    = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE   = 2'd2;

    localparam int                WIDTH_RESET  = 640;
    localparam int                HEIGHT_RESET = 480;
    localparam logic [MODE_W-1:0] MODE_RESET   = 2'd1;

    localparam logic [MODE_W-1:0] MODE_QUAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BARS = 2'd2;

    // floor(s / 3) == (s * 683) >> 11 for every s below 2048
    localparam int GRAY_MUL   = 683;
    localparam int GRAY_SHIFT = 11;

    localparam int BAR_EDGE_RED   = 160;
    localparam int BAR_EDGE_GREEN = 320;
    localparam int BAR_EDGE_BLUE  = 480;

    localparam logic [CH_W-1:0] CH_FULL = 8'hFF;
    localparam logic [CH_W-1:0] CH_NONE = 8'h00;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [1:0] KIND_LEFT = 2'd0;
    localparam logic [1:0] KIND_PASS = 2'd1;
    localparam logic [1:0] KIND_GRAY = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] pix_c0;
        logic [CH_W-1:0] pix_c1;
        logic [CH_W-1:0] pix_c2;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] out_c0;
        logic [CH_W-1:0] out_c1;
        logic [CH_W-1:0] out_c2;
        logic            end_of_line;
        logic            end_of_frame;
    } t_pix_out;

    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] c2;
    } t_rgb;

    typedef struct packed {
        logic [1:0]       kind;
        t_rgb             pix;
        logic [SUM_W-1:0] sum;
        logic             eol;
        logic             eof;
    } t_job;

endpackage

[rtl/qvvc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module qvvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/qvvc_fifo.sv]
// Small register FIFO with fill count, used for the job and result queues.
// Depends on nothing.
`timescale 1ns / 1ps

module qvvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTRW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CNTW-1:0]  o_count
);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTRW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_slot[r_rd_ptr];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
        end
        if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
        end
        if (w_push_ok && !w_pop_ok) begin
            n_count = r_count + CNTW'(1);
        end else if (w_pop_ok && !w_push_ok) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/qvvc_front.sv]
// Front end: tracks the raster position, classifies each pixel slot and
// builds a job for the back end. Depends on qvvc_pkg.
`timescale 1ns / 1ps

module qvvc_front import qvvc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  t_pix_in           i_pix,
    input  logic [WW-1:0]     i_width,
    input  logic [HW-1:0]     i_height,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_job_valid,
    output t_job              o_job,
    output logic [AW-1:0]     o_job_addr,
    input  logic              i_job_full
);

    localparam int PW = $clog2(2 * MAX_WIDTH);
    localparam int RW = $clog2(2 * MAX_HEIGHT);
    localparam int JX = PW + 1;
    localparam int RX = RW + 1;
    localparam int CW = (PW > 9) ? PW : 9;

    logic [PW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          w_accept;
    logic          w_left;
    logic          w_last_col;
    logic          w_last_row;
    logic          w_bars;
    logic [JX-1:0] w_diff;
    logic [JX-1:0] w_rd_addr;
    logic [CW-1:0] w_col_ext;
    t_rgb          w_bar_rgb;
    t_rgb          w_rgb;

    assign w_accept    = i_push && !i_job_full;
    assign o_full      = i_job_full;
    assign o_job_valid = w_accept;

    always_comb begin
        w_left     = JX'(r_col) < JX'(i_width);
        w_last_col = (JX'(r_col) + JX'(1)) >= (JX'(i_width) << 1);
        w_last_row = (RX'(r_row) + RX'(1)) >= (RX'(i_height) << 1);
        w_bars     = (RX'(r_row) >= RX'(i_height)) && (i_mode >= MODE_BARS);
        w_col_ext  = CW'(r_col);

        priority if (w_col_ext < CW'(BAR_EDGE_RED)) begin
            w_bar_rgb = '{c0: CH_FULL, c1: CH_NONE, c2: CH_NONE};
        end else if (w_col_ext < CW'(BAR_EDGE_GREEN)) begin
            w_bar_rgb = '{c0: CH_NONE, c1: CH_FULL, c2: CH_NONE};
        end else if (w_col_ext < CW'(BAR_EDGE_BLUE)) begin
            w_bar_rgb = '{c0: CH_NONE, c1: CH_NONE, c2: CH_FULL};
        end else begin
            w_bar_rgb = '{c0: CH_FULL, c1: CH_FULL, c2: CH_FULL};
        end

        if (w_left && w_bars) begin
            w_rgb = w_bar_rgb;
        end else begin
            w_rgb = '{c0: i_pix.pix_c0, c1: i_pix.pix_c1, c2: i_pix.pix_c2};
        end

        w_diff = JX'(r_col) - JX'(i_width);
        if (w_diff >= JX'(MAX_WIDTH)) begin
            w_rd_addr = w_diff - JX'(MAX_WIDTH);
        end else begin
            w_rd_addr = w_diff;
        end

        o_job.pix = w_rgb;
        o_job.sum = SUM_W'(w_rgb.c0) + SUM_W'(w_rgb.c1) + SUM_W'(w_rgb.c2);
        o_job.eol = w_last_col;
        o_job.eof = w_last_col && w_last_row;
        if (w_left) begin
            o_job.kind = KIND_LEFT;
            o_job_addr = r_col[AW-1:0];
        end else if (i_mode == MODE_QUAD) begin
            o_job.kind = KIND_PASS;
            o_job_addr = w_rd_addr[AW-1:0];
        end else begin
            o_job.kind = KIND_GRAY;
            o_job_addr = w_rd_addr[AW-1:0];
        end

        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[rtl/qvvc_back.sv]
// Back end: runs jobs against the gray line store and queues finished pixels.
// Depends on qvvc_pkg, qvvc_ram, qvvc_fifo and the assertion macro header.
`timescale 1ns / 1ps
`include "quad_view_video_compositor_core_defines.svh"

module qvvc_back import qvvc_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  t_job          i_job,
    input  logic [AW-1:0] i_job_addr,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output t_pix_out      o_res
);

    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam int CRW   = OCW + 1;
    localparam int OUT_W = $bits(t_pix_out);

    logic              w_issue;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [PROD_W-1:0] w_prod;
    logic [CH_W-1:0]   w_gray_wr;
    logic [CH_W-1:0]   w_gray_rd;
    logic              r_s2_valid;
    t_job              r_s2_job;
    t_pix_out          w_s2_res;
    logic              w_out_full;
    logic [OCW-1:0]    w_out_count;
    logic [OUT_W-1:0]  w_out_data;

    assign w_issue   = i_job_valid &&
                       ((CRW'(w_out_count) + CRW'(r_s2_valid)) < CRW'(OUT_DEPTH));
    assign o_job_pop = w_issue;
    assign w_ram_we  = w_issue && (i_job.kind == KIND_LEFT);
    assign w_ram_re  = w_issue && (i_job.kind == KIND_GRAY);
    assign w_prod    = PROD_W'(i_job.sum) * PROD_W'(GRAY_MUL);
    assign w_gray_wr = w_prod[GRAY_SHIFT +: CH_W];

    qvvc_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_WIDTH)
    ) u_gray_line (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_job_addr),
        .i_wdata (w_gray_wr),
        .i_raddr (i_job_addr),
        .o_rdata (w_gray_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s2_job <= i_job;
        end
    end

    always_comb begin
        w_s2_res.end_of_line  = r_s2_job.eol;
        w_s2_res.end_of_frame = r_s2_job.eof;
        if (r_s2_job.kind == KIND_GRAY) begin
            w_s2_res.out_c0 = w_gray_rd;
            w_s2_res.out_c1 = w_gray_rd;
            w_s2_res.out_c2 = w_gray_rd;
        end else begin
            w_s2_res.out_c0 = r_s2_job.pix.c0;
            w_s2_res.out_c1 = r_s2_job.pix.c1;
            w_s2_res.out_c2 = r_s2_job.pix.c2;
        end
    end

    qvvc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (w_s2_res),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign o_res = w_out_data;

    `QVVC_ASSERT_NEVER(a_out_overflow, i_clk, i_rst_n, r_s2_valid && w_out_full)
    `QVVC_ASSERT(a_credit_bound, i_clk, i_rst_n, (CRW'(w_out_count) + CRW'(r_s2_valid)) <= CRW'(OUT_DEPTH))
    `QVVC_ASSERT(a_waddr_range, i_clk, i_rst_n, w_ram_we |-> ((AW + 1)'(i_job_addr) < (AW + 1)'(MAX_WIDTH)))
    `QVVC_ASSERT(a_raddr_range, i_clk, i_rst_n, w_ram_re |-> ((AW + 1)'(i_job_addr) < (AW + 1)'(MAX_WIDTH)))

endmodule

[rtl/quad_view_video_compositor_core.sv]
// Top level of the quad-view video compositor: register file, front end,
// job queue and back end. Depends on qvvc_pkg, qvvc_front, qvvc_fifo, qvvc_back.
`timescale 1ns / 1ps

// Takes one pixel slot request per clock, accepted while full is low, and
// returns one output pixel per clock while results are ready and popped, in
// raster order over a frame of twice the source width and height. A result
// passes through the job queue, the back end's stage-two register and the
// result queue before it appears on o_res. The front end registers each
// classified slot into a four-entry job queue; the back end, while the result
// queue has room, issues one job per clock to the gray line store (at most one
// write or one read per job, read data registered) and drops the finished pixel
// into a four-entry result queue, so the input keeps moving while results
// wait, until the queues fill. Sizes are clamped to 1..MAX_WIDTH/MAX_HEIGHT on
// write; write the registers only while no request is in flight.
module quad_view_video_compositor_core import qvvc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_pix_in              i_pix,
    output logic                 empty,
    input  logic                 pop,
    output t_pix_out             o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CXW   = (SIZE_W > WW) ? SIZE_W : WW;
    localparam int CXH   = (SIZE_W > HW) ? SIZE_W : HW;
    localparam int JOB_W = $bits(t_job);
    localparam int MCW   = $clog2(MID_DEPTH + 1);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WW-1:0]       r_width, n_width;
    logic [HW-1:0]       r_height, n_height;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [CXW-1:0]      w_wr_w;
    logic [CXH-1:0]      w_wr_h;
    logic [CXW-1:0]      w_cl_w;
    logic [CXH-1:0]      w_cl_h;

    logic                w_job_valid;
    t_job                w_job;
    logic [AW-1:0]       w_job_addr;
    logic                w_mid_full;
    logic                w_mid_empty;
    logic                w_mid_pop;
    logic [MCW-1:0]      w_mid_count;
    logic [JOB_W+AW-1:0] w_mid_data;
    t_job                w_mid_job;
    logic [AW-1:0]       w_mid_addr;

    always_comb begin
        w_wr_w = CXW'(i_cfg_data);
        w_wr_h = CXH'(i_cfg_data);
        if (w_wr_w == '0) begin
            w_cl_w = CXW'(1);
        end else if (w_wr_w > CXW'(MAX_WIDTH)) begin
            w_cl_w = CXW'(MAX_WIDTH);
        end else begin
            w_cl_w = w_wr_w;
        end
        if (w_wr_h == '0) begin
            w_cl_h = CXH'(1);
        end else if (w_wr_h > CXH'(MAX_HEIGHT)) begin
            w_cl_h = CXH'(MAX_HEIGHT);
        end else begin
            w_cl_h = w_wr_h;
        end

        n_width  = r_width;
        n_height = r_height;
        n_mode   = r_mode;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SOURCE_WIDTH:  n_width  = WW'(w_cl_w);
                REG_SOURCE_HEIGHT: n_height = HW'(w_cl_h);
                REG_LAYOUT_MODE:   n_mode   = i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RST);
            r_height <= HW'(H_RST);
            r_mode   <= MODE_RESET;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_mode   <= n_mode;
        end
    end

    qvvc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pix       (i_pix),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_mode      (r_mode),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .o_job_addr  (w_job_addr),
        .i_job_full  (w_mid_full)
    );

    qvvc_fifo #(
        .WIDTH (JOB_W + AW),
        .DEPTH (MID_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_data  ({w_job_addr, w_job}),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    assign w_mid_job  = w_mid_data[JOB_W-1:0];
    assign w_mid_addr = w_mid_data[JOB_W +: AW];

    qvvc_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_mid_empty && (w_mid_count != '0)),
        .i_job       (w_mid_job),
        .i_job_addr  (w_mid_addr),
        .o_job_pop   (w_mid_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (o_res)
    );

endmodule
